[sv/csem_pkg.sv]
`default_nettype none

package csem_pkg;

  localparam int unsigned CntW = 16;
  localparam logic signed [CntW-1:0] CntMax = 16'sh7FFF;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_INIT    = 3'd1,
    CMD_DESTROY = 3'd2,
    CMD_WAIT    = 3'd3,
    CMD_POST    = 3'd4
  } csem_cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BLOCKED    = 3'd1,
    ST_NO_FREE    = 3'd2,
    ST_BAD_HANDLE = 3'd3,
    ST_QUEUE_FULL = 3'd4,
    ST_COUNT_OVF  = 3'd5
  } csem_status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } csem_state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  sem_id;
    logic [14:0] init_count;
    logic [5:0]  proc_id;
  } csem_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] alloc_id;
    logic       wake_valid;
    logic [5:0] wake_proc;
  } csem_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } csem_ctrl_t;

endpackage

`default_nettype wire

[sv/csem_ctrl.sv]
`default_nettype none

module csem_ctrl import csem_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output csem_ctrl_t ctrl_o,
  output logic       busy_o,
  output logic       done_o
);

  csem_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = start_i ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o         = (state_q == S_EXEC);
    done_o         = (state_q == S_RESP);
    ctrl_o.exec    = (state_q == S_EXEC);
    ctrl_o.capture = start_i && (state_q != S_EXEC);
  end

  a_cap_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.capture |=> ctrl_o.exec)
    else $error("capture not followed by execute");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.exec |=> done_o && !busy_o)
    else $error("execute not followed by result strobe");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

[sv/csem_dp.sv]
`default_nettype none

module csem_dp import csem_pkg::*; #(
  parameter int unsigned NUM_SEMS  = 16,
  parameter int unsigned NUM_PROCS = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire csem_ctrl_t ctrl_i,
  input  wire csem_req_t  req_i,
  output csem_rsp_t       rsp_o
);

  localparam int unsigned IdW    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int unsigned PtrW   = $clog2(NUM_PROCS);
  localparam int unsigned QDepth = NUM_SEMS * (1 << PtrW);
  localparam logic signed [CntW-1:0] CntFloor = CntW'(-$signed(NUM_PROCS));
  localparam logic [PtrW-1:0] PtrLast = PtrW'(NUM_PROCS - 1);

  // Per-entry stores
  logic signed [CntW-1:0] cnt_mem  [NUM_SEMS];
  logic [PtrW-1:0]        head_mem [NUM_SEMS];
  logic [PtrW-1:0]        tail_mem [NUM_SEMS];
  logic [5:0]             q_mem    [QDepth];
  logic [NUM_SEMS-1:0]    alloc_q;

  csem_req_t              req_q;
  logic signed [CntW-1:0] cnt_rd_q;
  logic [PtrW-1:0]        head_rd_q, tail_rd_q;
  logic [5:0]             q_rd_q;
  logic [2:0]             status_q;
  logic [3:0]             alloc_id_q;
  logic                   wake_valid_q;

  logic [IdW-1:0]         idx_i, idx_q;
  logic                   in_range, handle_ok;
  logic [2:0]             status_d;
  logic [3:0]             grant_d;
  logic                   wake_d;
  logic                   alloc_set, alloc_clr;
  logic [IdW-1:0]         alloc_idx;
  logic                   cnt_we, head_we, tail_we, q_we, q_re;
  logic signed [CntW-1:0] cnt_wdata;
  logic [PtrW-1:0]        head_wdata, tail_wdata;
  logic                   found;

  assign idx_i     = IdW'(req_i.sem_id);
  assign idx_q     = IdW'(req_q.sem_id);
  assign in_range  = (32'(req_q.sem_id) < 32'(NUM_SEMS));
  assign handle_ok = in_range && alloc_q[idx_q];

  // Read the entry state on capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      req_q     <= req_i;
      cnt_rd_q  <= cnt_mem[idx_i];
      head_rd_q <= head_mem[idx_i];
      tail_rd_q <= tail_mem[idx_i];
    end
  end

  always_comb begin
    status_d   = ST_OK;
    grant_d    = '0;
    wake_d     = 1'b0;
    alloc_set  = 1'b0;
    alloc_clr  = 1'b0;
    alloc_idx  = idx_q;
    cnt_we     = 1'b0;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    q_we       = 1'b0;
    q_re       = 1'b0;
    cnt_wdata  = cnt_rd_q;
    head_wdata = '0;
    tail_wdata = '0;
    found      = 1'b0;
    if (req_q.cmd == CMD_ALLOC) begin
      // lowest free entry wins
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
        if (!alloc_q[i]) begin
          found     = 1'b1;
          alloc_idx = IdW'(i);
        end
      end
      if (found) begin
        alloc_set = 1'b1;
        grant_d   = 4'(alloc_idx);
      end else begin
        status_d = ST_NO_FREE;
      end
    end else if (!handle_ok) begin
      status_d = ST_BAD_HANDLE;
    end else begin
      unique case (req_q.cmd)
        CMD_INIT: begin
          cnt_we     = 1'b1;
          cnt_wdata  = {1'b0, req_q.init_count};
          head_we    = 1'b1;
          tail_we    = 1'b1;
        end
        CMD_DESTROY: begin
          alloc_clr = 1'b1;
        end
        CMD_WAIT: begin
          if (cnt_rd_q <= CntFloor) begin
            status_d = ST_QUEUE_FULL;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd_q - 16'sd1;
            // count goes negative: enqueue caller at the tail
            if (cnt_rd_q <= 16'sd0) begin
              status_d   = ST_BLOCKED;
              q_we       = 1'b1;
              tail_we    = 1'b1;
              tail_wdata = (tail_rd_q == PtrLast) ? '0 : tail_rd_q + 1'b1;
            end
          end
        end
        CMD_POST: begin
          if (cnt_rd_q == CntMax) begin
            status_d = ST_COUNT_OVF;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd_q + 16'sd1;
            // waiters remain: dequeue the head
            if (cnt_rd_q[CntW-1]) begin
              wake_d     = 1'b1;
              q_re       = 1'b1;
              head_we    = 1'b1;
              head_wdata = (head_rd_q == PtrLast) ? '0 : head_rd_q + 1'b1;
            end
          end
        end
        default: begin
          status_d = ST_BAD_HANDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      if (cnt_we)  cnt_mem[idx_q]  <= cnt_wdata;
      if (head_we) head_mem[idx_q] <= head_wdata;
      if (tail_we) tail_mem[idx_q] <= tail_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && q_we) q_mem[{idx_q, tail_rd_q}] <= req_q.proc_id;
    if (ctrl_i.exec && q_re) q_rd_q <= q_mem[{idx_q, head_rd_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q      <= '0;
      status_q     <= ST_OK;
      alloc_id_q   <= '0;
      wake_valid_q <= 1'b0;
    end else if (ctrl_i.exec) begin
      if (alloc_set) alloc_q[alloc_idx] <= 1'b1;
      if (alloc_clr) alloc_q[idx_q]     <= 1'b0;
      status_q     <= status_d;
      alloc_id_q   <= grant_d;
      wake_valid_q <= wake_d;
    end
  end

  assign rsp_o.status     = status_q;
  assign rsp_o.alloc_id   = alloc_id_q;
  assign rsp_o.wake_valid = wake_valid_q;
  assign rsp_o.wake_proc  = wake_valid_q ? q_rd_q : '0;

  a_enq_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.exec && q_we |-> status_d == ST_BLOCKED && !q_re)
    else $error("enqueue without blocked status");

  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wake_valid_q |-> status_q == ST_OK)
    else $error("wakeup reported with error status");

  a_no_free_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ctrl_i.exec) && status_q == ST_NO_FREE |-> &alloc_q)
    else $error("no free entry reported while an entry is free");

endmodule

`default_nettype wire

[sv/counting_semaphore_table.sv]
// done_o rises once the controller has gone from execute to result state. A new command
// is taken in idle or while a result is shown; busy is high only in the execute cycle,
//   which holds the read-modify-write of the count, pointer and wait-ring memories.
// Results cannot be stalled: done_o marks each one on rsp_o for exactly one cycle.
// Reset clears the controller, the allocated marks and the result registers;
//   counts and pointers are undefined until an initialize writes them, ring slots until a wait.
`default_nettype none

module counting_semaphore_table import csem_pkg::*; #(
  parameter int unsigned NUM_SEMS  = 16,
  parameter int unsigned NUM_PROCS = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire csem_req_t req_i,
  output logic           done_o,
  output csem_rsp_t      rsp_o
);

  // Command path between controller and datapath
  csem_ctrl_t ctrl;

  // Sequence each transaction: capture and read, execute and write back,
  // then present the result for one cycle. A new transaction may be taken
  // while the previous result is on the ports, since all writes are done.
  csem_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .ctrl_o  (ctrl),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Hold the semaphore table: allocated marks in flops, counts, ring
  // pointers and the wait rings in memories with registered reads.
  csem_dp #(
    .NUM_SEMS  (NUM_SEMS),
    .NUM_PROCS (NUM_PROCS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  a_busy_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("busy and result strobe together");

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 done_o)
    else $error("accepted transaction gave no result");

  a_wake_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.wake_valid |-> rsp_o.alloc_id == '0)
    else $error("wakeup together with a grant");

endmodule

`default_nettype wire
